[rtl/aec_pkg.sv]
// Shared types, constants and helper functions for the audio effects chain.
// Used by audio_effects_chain_core and aec_mul.
package aec_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_BITS = 8;
  localparam int ACC_W = SAMPLE_W + FRAC_BITS;    // lowpass accumulator
  localparam int STORE_W = 26;                    // delay line entries
  localparam int VAL_W = 28;                      // working value
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RACC_W = 46;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int TAP_IDX_W = 3;
  localparam int DELAY_W = 17;
  localparam int ALPHA_W = 17;
  localparam int GAIN_W = 12;
  localparam int RECIP_W = 21;
  localparam int RECIP_SH = 20;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ECHO_EN  = 3'd0,
    REG_REVB_EN  = 3'd1,
    REG_DIST_EN  = 3'd2,
    REG_DELAY    = 3'd3,
    REG_ALPHA    = 3'd4,
    REG_GAIN     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LP, ST_LPW, ST_ECHO, ST_TQ, ST_TRD, ST_TMUL,
    ST_TACC, ST_RADD, ST_DMUL, ST_DCL, ST_FIN
  } state_t;

  // ceil(2^20 / (i+1)): exact floor division of a 17-bit value by i+1
  function automatic logic [RECIP_W-1:0] tap_recip(input logic [TAP_IDX_W-1:0] i);
    logic [RECIP_W-1:0] r;
    case (i)
      3'd0: r = 21'd1048576;
      3'd1: r = 21'd524288;
      3'd2: r = 21'd349526;
      3'd3: r = 21'd262144;
      3'd4: r = 21'd209716;
      3'd5: r = 21'd174763;
      3'd6: r = 21'd149797;
      default: r = 21'd131072;
    endcase
    return r;
  endfunction

  // round(0.3 * 65536 / (i+1))
  function automatic logic [14:0] tap_gain(input logic [TAP_IDX_W-1:0] i);
    logic [14:0] g;
    case (i)
      3'd0: g = 15'd19661;
      3'd1: g = 15'd9830;
      3'd2: g = 15'd6554;
      3'd3: g = 15'd4915;
      3'd4: g = 15'd3932;
      3'd5: g = 15'd3277;
      3'd6: g = 15'd2809;
      default: g = 15'd2458;
    endcase
    return g;
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [VAL_W-1:0] v);
    logic signed [STORE_W-1:0] r;
    if (v > VAL_W'(33554431)) r = STORE_W'(33554431);
    else if (v < -VAL_W'(33554432)) r = -STORE_W'(33554432);
    else r = STORE_W'(v);
    return r;
  endfunction

endpackage

[rtl/audio_effects_chain_core.sv]
// Audio effects chain: lowpass, feedback echo, multi-tap reverb, distortion.
// One sample is processed at a time by a sequencer around one shared
// multiplier. A sample passes through ST_LP and ST_LPW, then ST_ECHO for
// echo, ST_TQ, ST_TRD, ST_TMUL and ST_TACC for each reverb tap and ST_RADD
// for reverb, ST_DMUL and ST_DCL for distortion, and ST_FIN, which waits
// while the output stays stalled. The reverb taps dominate, one delay-memory
// read each. After reset both delay memories are cleared one entry per cycle,
// with in_ready low. DELAY_DEPTH must be a power of two.
// Depends on aec_pkg, aec_ram, aec_mul.
module audio_effects_chain_core
  import aec_pkg::*;
#(
  parameter int DELAY_DEPTH = 131072,
  parameter int REVERB_TAPS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       last_in_block,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       last_out,
  output logic                       saturated,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(REVERB_TAPS - 1);

  // configuration
  logic               echo_en, revb_en, dist_en;
  logic [DELAY_W-1:0] delay;
  logic [ALPHA_W-1:0] alpha;
  logic [GAIN_W-1:0]  gain;

  state_t state, state_next;

  logic signed [ACC_W-1:0]  x, acc;
  logic signed [VAL_W-1:0]  v;
  logic signed [RACC_W-1:0] racc;
  logic [TAP_IDX_W-1:0]     ti;
  logic [DELAY_W-1:0]       tq;
  logic [ADDR_W-1:0]        wp, clr_addr;
  logic                     last_r, sat_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic                       echo_we, echo_re, revb_we, revb_re;
  logic [ADDR_W-1:0]          echo_waddr, revb_waddr, revb_raddr;
  logic [STORE_W-1:0]         echo_wdata, revb_wdata, echo_q, revb_q;

  logic [ALPHA_W-1:0]         alpha_c;
  logic signed [ACC_W-1:0]    acc_new;
  logic [DELAY_W+RECIP_W-1:0] quot_full;
  logic signed [VAL_W-1:0]    echo_sum;
  logic signed [MUL_P_W-1:0]  dist_v;
  logic signed [VAL_W-1:0]    v_rnd;
  logic signed [VAL_W-FRAC_BITS-1:0] q_full;
  logic                       in_xfer, out_free;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  assign alpha_c = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign acc_new = (alpha_c == '0) ? x : ACC_W'(acc + ACC_W'(prod >>> 16));
  assign quot_full = (DELAY_W + RECIP_W)'(delay) * (DELAY_W + RECIP_W)'(tap_recip(ti));
  assign echo_sum = v + VAL_W'($signed(echo_q) >>> 1);
  assign dist_v = prod >>> 8;
  assign v_rnd = v + ((v < 0) ? VAL_W'((1 << FRAC_BITS) - 1) : VAL_W'(0));
  assign q_full = VAL_W'(v_rnd >>> FRAC_BITS) > VAL_W'(0) ? (VAL_W-FRAC_BITS)'(v_rnd >>> FRAC_BITS)
                  : (VAL_W-FRAC_BITS)'(v_rnd >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en <= 1'b0;
      revb_en <= 1'b0;
      dist_en <= 1'b0;
      delay   <= DELAY_W'(22050);
      alpha   <= ALPHA_W'(6554);
      gain    <= GAIN_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECHO_EN: echo_en <= cfg_wdata[0];
        REG_REVB_EN: revb_en <= cfg_wdata[0];
        REG_DIST_EN: dist_en <= cfg_wdata[0];
        REG_DELAY:   delay   <= cfg_wdata[DELAY_W-1:0];
        REG_ALPHA:   alpha   <= cfg_wdata[ALPHA_W-1:0];
        REG_GAIN:    gain    <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DELAY_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_next = ST_LP;
      ST_LP:    state_next = ST_LPW;
      ST_LPW: begin
        if (echo_en) state_next = ST_ECHO;
        else if (revb_en) state_next = ST_TQ;
        else if (dist_en) state_next = ST_DMUL;
        else state_next = ST_FIN;
      end
      ST_ECHO: begin
        if (revb_en) state_next = ST_TQ;
        else if (dist_en) state_next = ST_DMUL;
        else state_next = ST_FIN;
      end
      ST_TQ:   state_next = ST_TRD;
      ST_TRD:  state_next = ST_TMUL;
      ST_TMUL: state_next = ST_TACC;
      ST_TACC: state_next = (ti == LAST_TAP) ? ST_RADD : ST_TQ;
      ST_RADD: state_next = dist_en ? ST_DMUL : ST_FIN;
      ST_DMUL: state_next = ST_DCL;
      ST_DCL:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = MUL_A_W'(x - acc);
    mul_b = MUL_B_W'(alpha_c);
    echo_re = 1'b0;
    echo_we = 1'b0;
    echo_waddr = wp;
    echo_wdata = sat_store(echo_sum);
    revb_re = 1'b0;
    revb_we = 1'b0;
    revb_waddr = wp;
    revb_wdata = sat_store(v);
    revb_raddr = ADDR_W'(wp - ADDR_W'(tq));
    unique case (state)
      ST_CLEAR: begin
        echo_we = 1'b1;
        revb_we = 1'b1;
        echo_waddr = clr_addr;
        revb_waddr = clr_addr;
        echo_wdata = '0;
        revb_wdata = '0;
      end
      ST_LP:   echo_re = 1'b1;
      ST_ECHO: echo_we = 1'b1;
      ST_TRD:  revb_re = 1'b1;
      ST_TMUL: begin
        mul_a = MUL_A_W'($signed(revb_q));
        mul_b = MUL_B_W'(tap_gain(ti));
      end
      ST_RADD: revb_we = 1'b1;
      ST_DMUL: begin
        mul_a = MUL_A_W'(v);
        mul_b = MUL_B_W'(gain);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_LPW) acc <= acc_new;
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
        wp <= wp + 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          x      <= ACC_W'(in_sample) <<< FRAC_BITS;
          last_r <= last_in_block;
          sat_r  <= 1'b0;
        end
      end
      ST_LPW: begin
        v    <= VAL_W'(acc_new);
        racc <= '0;
        ti   <= '0;
      end
      ST_ECHO: v <= VAL_W'(sat_store(echo_sum));
      ST_TQ:   tq <= DELAY_W'(quot_full >> RECIP_SH);
      ST_TACC: begin
        racc <= racc + RACC_W'(prod);
        ti   <= ti + 1'b1;
      end
      ST_RADD: v <= v + VAL_W'(racc >>> 16);
      ST_DCL: begin
        if (dist_v > MUL_P_W'(32767 * 256)) begin
          v <= VAL_W'(32767 * 256);
          sat_r <= 1'b1;
        end else if (dist_v < -MUL_P_W'(32768 * 256)) begin
          v <= -VAL_W'(32768 * 256);
          sat_r <= 1'b1;
        end else begin
          v <= VAL_W'(dist_v);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          last_out <= last_r;
          if (q_full > (VAL_W-FRAC_BITS)'(32767)) begin
            out_sample <= SAMPLE_W'(32767);
            saturated  <= 1'b1;
          end else if (q_full < -(VAL_W-FRAC_BITS)'(32768)) begin
            out_sample <= -SAMPLE_W'(32768);
            saturated  <= 1'b1;
          end else begin
            out_sample <= SAMPLE_W'(q_full);
            saturated  <= sat_r;
          end
        end
      end
      default: ;
    endcase
  end

  aec_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  aec_ram #(.DEPTH(DELAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(STORE_W)) u_echo_ram (
    .clk   (clk),
    .we    (echo_we),
    .waddr (echo_waddr),
    .wdata (echo_wdata),
    .re    (echo_re),
    .raddr (ADDR_W'(wp - ADDR_W'(delay))),
    .rdata (echo_q)
  );

  aec_ram #(.DEPTH(DELAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(STORE_W)) u_revb_ram (
    .clk   (clk),
    .we    (revb_we),
    .waddr (revb_waddr),
    .wdata (revb_wdata),
    .re    (revb_re),
    .raddr (revb_raddr),
    .rdata (revb_q)
  );

endmodule

[rtl/aec_ram.sv]
// Single-port-write, single-port-read delay memory with registered read data.
// Depends on nothing.
module aec_ram #(
  parameter int DEPTH = 131072,
  parameter int ADDR_W = 17,
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/aec_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on aec_pkg.
module aec_mul
  import aec_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
